// ===== hdl/cdrs_pkg.sv =====
// shared constants, types and helpers for the c-scan request scheduler
// no dependencies; imported by the front end, the back end, the top level and the testbench
package cdrs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int TRACK_BITS  = 16;

  localparam int TRK_W   = 16;
  localparam int NT_W    = 17;
  localparam int SEEK_W  = 18;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int IN_DATA_W  = ((TRK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TRK_W + SEEK_W + 7) / 8) * 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // highest track the track field can express
  localparam logic [NT_W-1:0] TRACK_LIM = NT_W'((64'd1 << TRACK_BITS) - 64'd1);

  localparam logic [NT_W-1:0]    NUM_TRACKS_RST = NT_W'(65536);
  localparam logic [TRK_W-1:0]   START_HEAD_RST = '0;
  localparam logic [CNT_W-1:0]   DEPTH_CNT      = CNT_W'(QUEUE_DEPTH);

  // register index, taken from paddr bit 2
  localparam logic REG_NUM_TRACKS = 1'b0;
  localparam logic REG_START_HEAD = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SERVICE = 2'd0,
    KIND_SWEEP   = 2'd1,
    KIND_JUMP    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TRK_W-1:0] track;
    logic             last;
  } q_item_t;

  typedef struct packed {
    logic [TRK_W-1:0] top;
    logic [TRK_W-1:0] head0;
  } sched_cfg_t;

  function automatic logic [TRK_W-1:0] clamp_track(input logic [TRK_W-1:0] trk,
                                                   input logic [TRK_W-1:0] top);
    clamp_track = (trk > top) ? top : trk;
  endfunction

endpackage

// ===== hdl/cdrs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module cdrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cdrs_front.sv =====
// front end: accepts request transfers, clamps the track and queues them
// depends on cdrs_pkg
module cdrs_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [cdrs_pkg::TRK_W-1:0] in_track,
  input  logic                    in_last,
  input  logic [cdrs_pkg::TRK_W-1:0] top,
  output logic                    q_valid,
  input  logic                    q_ready,
  output cdrs_pkg::q_item_t       q_item
);
  import cdrs_pkg::*;

  q_item_t    fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r].track <= clamp_track(in_track, top);
      fifo_r[wr_ptr_r].last  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/cdrs_back.sv =====
// back end: sorted insertion into the request ram and c-scan schedule output
// depends on cdrs_pkg and cdrs_ram
module cdrs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdrs_pkg::sched_cfg_t        cfg,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  cdrs_pkg::q_item_t           q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cdrs_pkg::TRK_W-1:0]  out_track,
  output logic [cdrs_pkg::KIND_W-1:0] out_kind,
  output logic [cdrs_pkg::SEEK_W-1:0] out_seek,
  output logic                        out_last
);
  import cdrs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_INS_CMP   = 11'b000_0000_0010,
    S_INS_PUT   = 11'b000_0000_0100,
    S_SPLIT_RD  = 11'b000_0000_1000,
    S_SPLIT_CMP = 11'b000_0001_0000,
    S_P1_RD     = 11'b000_0010_0000,
    S_P1_EMIT   = 11'b000_0100_0000,
    S_SWEEP     = 11'b000_1000_0000,
    S_JUMP      = 11'b001_0000_0000,
    S_P2_RD     = 11'b010_0000_0000,
    S_P2_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    ins_r, ins_nxt;
  logic [CNT_W-1:0]    split_r, split_nxt;
  logic [CNT_W-1:0]    cur_r, cur_nxt;
  logic [TRK_W-1:0]    trk_r, trk_nxt;
  logic                last_r, last_nxt;
  logic [TRK_W-1:0]    head_r, head_nxt;
  logic [SEEK_W-1:0]   seek_r, seek_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [TRK_W-1:0]    out_track_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [SEEK_W-1:0]   out_seek_r;
  logic                out_last_r;

  logic                we;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [TRK_W-1:0]    wdata, rdata;

  logic                slot_free;
  logic                emit;
  logic [TRK_W-1:0]    emit_track;
  kind_t               emit_kind;
  logic                emit_last;
  logic [TRK_W-1:0]    move_dist;
  logic [CNT_W-1:0]    cur_dec;

  cdrs_ram #(
    .WIDTH (TRK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign cur_dec   = cur_r - 1'b1;
  assign q_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ins_nxt    = ins_r;
    split_nxt  = split_r;
    cur_nxt    = cur_r;
    trk_nxt    = trk_r;
    last_nxt   = last_r;
    head_nxt   = head_r;
    seek_nxt   = seek_r;
    we         = 1'b0;
    waddr      = ins_r;
    wdata      = trk_r;
    raddr      = IDX_W'(cur_dec);
    emit       = 1'b0;
    emit_track = rdata;
    emit_kind  = KIND_SERVICE;
    emit_last  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        raddr = IDX_W'(count_r - 1'b1);
        if (q_valid) begin
          trk_nxt  = q_item.track;
          last_nxt = q_item.last;
          ins_nxt  = IDX_W'(count_r);
          if (count_r == DEPTH_CNT) begin
            // store full: request dropped, a last mark still runs the schedule
            if (q_item.last) begin
              head_nxt  = cfg.head0;
              seek_nxt  = '0;
              split_nxt = '0;
              state_nxt = S_SPLIT_RD;
            end
          end else if (count_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            state_nxt = S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        // rdata holds entry ins_r-1
        raddr = ins_r - IDX_W'(2);
        if (rdata > trk_r) begin
          we      = 1'b1;
          waddr   = ins_r;
          wdata   = rdata;
          ins_nxt = ins_r - 1'b1;
          if (ins_r == IDX_W'(1)) begin
            state_nxt = S_INS_PUT;
          end
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        we        = 1'b1;
        waddr     = ins_r;
        wdata     = trk_r;
        count_nxt = count_r + 1'b1;
        if (last_r) begin
          head_nxt  = cfg.head0;
          seek_nxt  = '0;
          split_nxt = '0;
          state_nxt = S_SPLIT_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SPLIT_RD: begin
        raddr = IDX_W'(split_r);
        if (split_r == count_r) begin
          cur_nxt   = split_r;
          state_nxt = S_P1_RD;
        end else begin
          state_nxt = S_SPLIT_CMP;
        end
      end
      S_SPLIT_CMP: begin
        raddr = IDX_W'(split_r);
        if (rdata <= head_r) begin
          split_nxt = split_r + 1'b1;
          state_nxt = S_SPLIT_RD;
        end else begin
          cur_nxt   = split_r;
          state_nxt = S_P1_RD;
        end
      end
      S_P1_RD: begin
        state_nxt = (cur_r == '0) ? S_SWEEP : S_P1_EMIT;
      end
      S_P1_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          cur_nxt   = cur_dec;
          state_nxt = S_P1_RD;
        end
      end
      S_SWEEP: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_track = '0;
          emit_kind  = KIND_SWEEP;
          state_nxt  = S_JUMP;
        end
      end
      S_JUMP: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_track = cfg.top;
          emit_kind  = KIND_JUMP;
          emit_last  = (split_r == count_r);
          cur_nxt    = count_r;
          if (split_r == count_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_P2_RD;
          end
        end
      end
      S_P2_RD: begin
        state_nxt = S_P2_EMIT;
      end
      S_P2_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = (cur_dec == split_r);
          cur_nxt   = cur_dec;
          if (cur_dec == split_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_P2_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    move_dist = (head_r > emit_track) ? (head_r - emit_track) : (emit_track - head_r);
    if (emit) begin
      head_nxt = emit_track;
      seek_nxt = seek_r + SEEK_W'(move_dist);
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    trk_r  <= trk_nxt;
    last_r <= last_nxt;
    ins_r  <= ins_nxt;
    split_r <= split_nxt;
    cur_r  <= cur_nxt;
    head_r <= head_nxt;
    seek_r <= seek_nxt;
    if (emit) begin
      out_track_r <= emit_track;
      out_kind_r  <= emit_kind;
      out_seek_r  <= seek_nxt;
      out_last_r  <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_track = out_track_r;
  assign out_kind  = out_kind_r;
  assign out_seek  = out_seek_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/cscan_disk_request_scheduler.sv =====
// c-scan request scheduler top level with config registers; uses cdrs_pkg, cdrs_front, cdrs_back
// the back end takes each request from the front-end queue and is busy with it while it
// shifts every stored entry above it up by one and then writes it in place
// a last request then scans the entries at or below the head; no new request is taken until
// its schedule is out; each serviced result waits on a registered ram read
// reset: synchronous active-low; empties the store, config back to 65536 tracks, head 0
module cscan_disk_request_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cdrs_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] request_track
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cdrs_pkg::OUT_DATA_W-1:0]    out_tdata,  // [15:0] visit_track, [33:16] seek_total
  output logic [cdrs_pkg::KIND_W-1:0]        out_tuser,  // [1:0] visit_kind
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cdrs_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [cdrs_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [cdrs_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import cdrs_pkg::*;

  logic [NT_W-1:0]   num_tracks_r;
  logic [TRK_W-1:0]  start_head_r;
  logic              cfg_wr;
  logic [NT_W-1:0]   top_raw;
  logic [TRK_W-1:0]  top;
  sched_cfg_t        sched_cfg;
  logic              q_valid, q_ready;
  q_item_t           q_item;
  logic [TRK_W-1:0]  visit_track;
  logic [SEEK_W-1:0] seek_total;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tracks_r <= NUM_TRACKS_RST;
      start_head_r <= START_HEAD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_NUM_TRACKS: num_tracks_r <= cfg_pwdata[NT_W-1:0];
        REG_START_HEAD: start_head_r <= cfg_pwdata[TRK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_NUM_TRACKS: cfg_prdata = CFG_DATA_W'(num_tracks_r);
      REG_START_HEAD: cfg_prdata = CFG_DATA_W'(start_head_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // zero tracks behaves as a single track
  always_comb begin
    top_raw = (num_tracks_r == '0) ? '0 : (num_tracks_r - 1'b1);
    top     = (top_raw > TRACK_LIM) ? TRACK_LIM[TRK_W-1:0] : top_raw[TRK_W-1:0];
    sched_cfg.top   = top;
    sched_cfg.head0 = clamp_track(start_head_r, top);
  end

  cdrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_track  (in_tdata[TRK_W-1:0]),
    .in_last   (in_tlast),
    .top       (top),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  cdrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (sched_cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_track (visit_track),
    .out_kind  (out_tuser),
    .out_seek  (seek_total),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'({seek_total, visit_track});

endmodule

// ===== tb/tb_cscan_disk_request_scheduler.sv =====
// self-checking testbench for the c-scan disk request scheduler: stream in, stream out, apb
// holds its own scheduler model and checks every result; depends on cdrs_pkg and the rtl
`timescale 1ns / 1ps

module tb_cscan_disk_request_scheduler;
  import cdrs_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 900;

  typedef struct packed {
    logic [TRK_W-1:0]  track;
    kind_t             kind;
    logic [SEEK_W-1:0] seek;
    logic              last;
  } visit_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // scheduler model state
  logic [TRK_W-1:0]  track_store [QUEUE_DEPTH];
  int                req_count;
  logic [TRK_W-1:0]  head_trk;
  logic [SEEK_W-1:0] seek_acc;
  logic [NT_W-1:0]   cfg_num_tracks;
  logic [TRK_W-1:0]  cfg_start_head;
  visit_t            expected_visits [$];

  visit_t want_visit;
  int     errors;
  int     idle_cycles;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_len;
  int     hold_seq;
  int     hold_seen;
  int     hold_left;

  cscan_disk_request_scheduler i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [15:0] request_track
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [15:0] visit_track, [33:16] seek_total
    .out_tuser   (out_tuser),    // [1:0] visit_kind
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [TRK_W-1:0] top_of_disk();
    logic [NT_W-1:0] t;
    t = (cfg_num_tracks == '0) ? '0 : cfg_num_tracks - 1'b1;
    return (t > TRACK_LIM) ? TRACK_LIM[TRK_W-1:0] : t[TRK_W-1:0];
  endfunction

  function automatic void add_visit(input logic [TRK_W-1:0] trk, input kind_t kind,
                                    input logic last);
    logic [TRK_W-1:0] move_dist;
    move_dist = (trk > head_trk) ? trk - head_trk : head_trk - trk;
    seek_acc = seek_acc + SEEK_W'(move_dist);
    head_trk = trk;
    expected_visits.push_back('{trk, kind, seek_acc, last});
  endfunction

  // insert one request in order; a last mark produces the whole service order
  function automatic void schedule_request(input logic [TRK_W-1:0] raw, input logic last);
    logic [TRK_W-1:0] top;
    logic [TRK_W-1:0] trk;
    int i;
    int split;
    top = top_of_disk();
    trk = (raw > top) ? top : raw;
    if (req_count < QUEUE_DEPTH) begin
      i = req_count;
      while (i > 0 && track_store[i-1] > trk) begin
        track_store[i] = track_store[i-1];
        i--;
      end
      track_store[i] = trk;
      req_count++;
    end
    if (!last) return;
    head_trk = (cfg_start_head > top) ? top : cfg_start_head;
    seek_acc = '0;
    split = 0;
    while (split < req_count && track_store[split] <= head_trk) split++;
    for (i = split; i > 0; i--) add_visit(track_store[i-1], KIND_SERVICE, 1'b0);
    add_visit('0, KIND_SWEEP, 1'b0);
    add_visit(top, KIND_JUMP, req_count == split);
    for (i = req_count; i > split; i--) add_visit(track_store[i-1], KIND_SERVICE, i == split + 1);
    req_count = 0;
    seek_acc = '0;
  endfunction

  task automatic send_request(input logic [TRK_W-1:0] trk, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(trk);
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    schedule_request(trk, last);
  endtask

  // idle the sender and let the schedule finish before any register access
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_reg(input logic [CFG_ADDR_W-1:0] addr, output logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_disk(input logic [NT_W-1:0] nt, input logic [TRK_W-1:0] sh);
    logic [CFG_DATA_W-1:0] rd;
    write_reg({REG_NUM_TRACKS, 2'b00}, CFG_DATA_W'(nt));
    write_reg({REG_START_HEAD, 2'b00}, CFG_DATA_W'(sh));
    cfg_num_tracks = nt;
    cfg_start_head = sh;
    read_reg({REG_NUM_TRACKS, 2'b00}, rd);
    if (rd !== CFG_DATA_W'(nt)) report_mismatch("num_tracks read", rd, CFG_DATA_W'(nt));
    read_reg({REG_START_HEAD, 2'b00}, rd);
    if (rd !== CFG_DATA_W'(sh)) report_mismatch("start_head read", rd, CFG_DATA_W'(sh));
  endtask

  function automatic logic [TRK_W-1:0] pick_track();
    logic [TRK_W-1:0] top;
    logic [TRK_W-1:0] hd;
    top = top_of_disk();
    hd  = (cfg_start_head > top) ? top : cfg_start_head;
    case ($urandom_range(11))
      0:       return '0;
      1:       return top;
      2:       return '1;
      3:       return hd;
      4:       return hd + TRK_W'($urandom_range(0, 2)) - 1'b1;
      5, 6, 7: return TRK_W'($urandom_range(0, int'(top)));
      default: return TRK_W'($urandom);
    endcase
  endfunction

  function automatic int pick_batch_len();
    case ($urandom_range(19))
      0:       return $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 2);
      1, 2:    return $urandom_range(13, QUEUE_DEPTH - 1);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic void pick_config(output logic [NT_W-1:0] nt, output logic [TRK_W-1:0] sh);
    case ($urandom_range(7))
      0:       nt = NUM_TRACKS_RST;
      1:       nt = NT_W'(1);
      2:       nt = '0;
      3:       nt = '1;
      4, 5:    nt = NT_W'($urandom_range(2, 64));
      default: nt = NT_W'($urandom_range(1, 65536));
    endcase
    case ($urandom_range(4))
      0:       sh = '0;
      1:       sh = '1;
      2:       sh = TRK_W'($urandom_range(0, 65535) % ((nt == '0) ? 1 : int'(nt)));
      default: sh = TRK_W'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int len);
    for (int n = 0; n < len; n++) send_request(pick_track(), n == len - 1);
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 8;
    recv_idle_pct = 62;
    // duplicates at the head, both track extremes
    configure_disk(NUM_TRACKS_RST, START_HEAD_RST);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'd1234, 1'b1);
    wait_drained();
    // clamping of requests above the top track, request equal to the head
    configure_disk(NT_W'(1000), TRK_W'(500));
    send_request(16'd999, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd500, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd501, 1'b1);
    // everything at or below the head, then nothing below it
    send_request(16'd100, 1'b0);
    send_request(16'd200, 1'b1);
    send_request(16'd500, 1'b1);
    send_request(16'd900, 1'b1);
    wait_drained();
    // zero tracks acts as a single track, head clamped too
    configure_disk('0, '1);
    send_request(16'h1234, 1'b1);
    wait_drained();
    configure_disk(NT_W'(1), '0);
    send_request(16'h0000, 1'b1);
    wait_drained();
    configure_disk('1, '1);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0001, 1'b1);
    wait_drained();
    configure_disk(NUM_TRACKS_RST, '1);
    send_request(16'hAAAA, 1'b0);
    send_request(16'h5555, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_batches(input int budget, input int send_pct, input int recv_pct);
    int sent;
    int len;
    logic [NT_W-1:0]  nt;
    logic [TRK_W-1:0] sh;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < budget) begin
      pick_config(nt, sh);
      configure_disk(nt, sh);
      repeat ($urandom_range(1, 3)) begin
        len = pick_batch_len();
        send_batch(len);
        sent += len;
      end
      wait_drained();
    end
  endtask

  // receiver holds off while a full batch and three short ones are sent, so the input must stall
  task automatic test_output_backpressure();
    logic [NT_W-1:0]  nt;
    logic [TRK_W-1:0] sh;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pick_config(nt, sh);
    configure_disk(nt, sh);
    hold_len = HOLD_CYCLES;
    hold_seq++;
    send_batch(QUEUE_DEPTH + 2);
    repeat (3) send_batch($urandom_range(4, 8));
    wait_drained();
  endtask

  // result side: random ready with an optional long hold
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_visits.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(out_tdata[TRK_W-1:0]), '0);
      end else begin
        want_visit = expected_visits.pop_front();
        if (out_tdata[TRK_W-1:0] !== want_visit.track)
          report_mismatch("visit_track", 32'(out_tdata[TRK_W-1:0]), 32'(want_visit.track));
        if (out_tdata[TRK_W +: SEEK_W] !== want_visit.seek)
          report_mismatch("seek_total", 32'(out_tdata[TRK_W +: SEEK_W]), 32'(want_visit.seek));
        if (out_tdata[OUT_DATA_W-1:TRK_W+SEEK_W] !== '0)
          report_mismatch("tdata padding", 32'(out_tdata[OUT_DATA_W-1:TRK_W+SEEK_W]), '0);
        if (out_tuser !== want_visit.kind)
          report_mismatch("visit_kind", 32'(out_tuser), 32'(want_visit.kind));
        if (out_tlast !== want_visit.last)
          report_mismatch("result_last", 32'(out_tlast), 32'(want_visit.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[cscan_disk_request_scheduler] ERROR");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    errors         = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_len       = 0;
    hold_seq       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    req_count      = 0;
    head_trk       = '0;
    seek_acc       = '0;
    cfg_num_tracks = NUM_TRACKS_RST;
    cfg_start_head = START_HEAD_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_batches(100, 8, 62);
    test_output_backpressure();
    test_random_batches(100, 62, 8);
    test_random_batches(100, 0, 0);

    wait_drained();
    if (errors == 0) begin
      $display("[cscan_disk_request_scheduler] OK");
    end else begin
      $display("[cscan_disk_request_scheduler] ERROR");
    end
    $finish;
  end

endmodule
